// ===== design/m4i_pkg.sv =====
// Shared types, widths, codes and index tables for the 4x4 matrix inverse unit.
package m4i_pkg;

    localparam int EW = 16;            // stored element width
    localparam int MW = 2 * EW + 1;    // 2x2 minor width, also the lane operand width
    localparam int PW = 2 * MW;        // lane product width
    localparam int AW = PW + 3;        // lane accumulator and determinant width
    localparam int CW = EW + MW + 2;   // cofactor width
    localparam int QW = 32;            // result element width
    localparam int RW = AW + 1;        // divider remainder width
    localparam int FRAC_SHIFT = 24;    // cofactor scale over determinant scale, Q16.16 result
    localparam int SPLIT = QW - FRAC_SHIFT;

    // merge stage operations
    localparam logic [1:0] MG_HOLD  = 2'd0;
    localparam logic [1:0] MG_SUM01 = 2'd1;
    localparam logic [1:0] MG_ADD2  = 2'd2;
    localparam logic [1:0] MG_ABS   = 2'd3;

    typedef logic signed [MW-1:0] t_opnd;
    typedef logic signed [AW-1:0] t_acc;

    typedef struct packed {
        logic signed [EW-1:0] elem0;
        logic signed [EW-1:0] elem1;
        logic signed [EW-1:0] elem2;
        logic signed [EW-1:0] elem3;
    } t_in_item;

    typedef struct packed {
        logic signed [QW-1:0] out0;
        logic signed [QW-1:0] out1;
        logic signed [QW-1:0] out2;
        logic signed [QW-1:0] out3;
        logic [1:0]           row_number;
        logic                 singular;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
    } t_mac_ctl;

    function automatic t_opnd f_sx(input logic signed [EW-1:0] x);
        return {{(MW-EW){x[EW-1]}}, x};
    endfunction

    // column pair (i, j) behind minor index m
    function automatic logic [1:0] f_pair_i(input logic [2:0] m);
        logic [1:0] v;
        unique case (m)
            3'd0, 3'd1, 3'd2: v = 2'd0;
            3'd3, 3'd4:       v = 2'd1;
            default:          v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] f_pair_j(input logic [2:0] m);
        logic [1:0] v;
        unique case (m)
            3'd0:       v = 2'd1;
            3'd1, 3'd3: v = 2'd2;
            default:    v = 2'd3;
        endcase
        return v;
    endfunction

    // t-th column left once column r is dropped
    function automatic logic [1:0] f_cof_col(input logic [1:0] r, input logic [1:0] t);
        return (t < r) ? t : 2'(t + 2'd1);
    endfunction

    // minor that pairs with column f_cof_col(r, t)
    function automatic logic [2:0] f_cof_minor(input logic [1:0] r, input logic [1:0] t);
        logic [2:0] v;
        unique case ({r, t})
            4'b00_00: v = 3'd5;
            4'b00_01: v = 3'd4;
            4'b00_10: v = 3'd3;
            4'b01_00: v = 3'd5;
            4'b01_01: v = 3'd2;
            4'b01_10: v = 3'd1;
            4'b10_00: v = 3'd4;
            4'b10_01: v = 3'd2;
            4'b10_10: v = 3'd0;
            4'b11_00: v = 3'd3;
            4'b11_01: v = 3'd1;
            4'b11_10: v = 3'd0;
            default:  v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/m4i_lane.sv =====
// One compute lane: multiply-accumulate and a restoring divider with saturation.
module m4i_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  m4i_pkg::t_mac_ctl         i_ctl,
    input  m4i_pkg::t_opnd            i_op_a,
    input  m4i_pkg::t_opnd            i_op_b,
    input  logic                      i_div_start,
    input  logic [m4i_pkg::AW-1:0]    i_dmag,
    input  logic                      i_dneg,
    output m4i_pkg::t_acc             o_acc,
    output logic [m4i_pkg::QW-1:0]    o_quot,
    output logic                      o_done
);
    import m4i_pkg::*;

    localparam int CNTW = $clog2(QW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(QW - 1);
    localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_PREP = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic signed [PW-1:0] r_prod;
    logic                 r_pen, r_pclr, r_pneg;
    t_acc                 r_acc, n_acc;
    logic signed [AW-1:0] w_base, w_pext;

    logic [1:0]           r_dst;
    logic [CNTW-1:0]      r_cnt;
    logic [CW-1:0]        r_num;
    logic                 r_qneg, r_big;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_sh, r_q;
    logic signed [CW-1:0] w_cof;
    logic [RW-1:0]        w_hi, w_trial;
    logic [RW:0]          w_diff;
    logic                 w_fit;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen  <= 1'b0;
            r_pclr <= 1'b0;
            r_pneg <= 1'b0;
        end else begin
            r_pen  <= i_ctl.en;
            r_pclr <= i_ctl.clr;
            r_pneg <= i_ctl.neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    // accumulate stage
    assign w_base = r_pclr ? '0 : r_acc;
    assign w_pext = {{(AW-PW){r_prod[PW-1]}}, r_prod};
    assign n_acc  = r_pneg ? (w_base - w_pext) : (w_base + w_pext);

    always_ff @(posedge i_clk) begin
        if (r_pen) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

    // divider: |cof| * 2^24 / |det|, one quotient bit a cycle
    assign w_cof   = r_acc[CW-1:0];
    assign w_hi    = RW'(r_num[CW-1:SPLIT]);
    assign w_trial = {r_rem[RW-2:0], r_sh[QW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, i_dmag};
    assign w_fit   = !w_diff[RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= D_IDLE;
            r_cnt <= '0;
        end else if (i_div_start) begin
            r_dst <= D_PREP;
        end else begin
            unique case (r_dst)
                D_PREP: begin
                    r_dst <= D_RUN;
                    r_cnt <= '0;
                end
                D_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_dst <= D_DONE;
                    end
                end
                D_IDLE, D_DONE: begin
                end
                default: r_dst <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_div_start) begin
            r_num  <= w_cof[CW-1] ? CW'(-w_cof) : CW'(w_cof);
            r_qneg <= w_cof[CW-1] ^ i_dneg;
        end else if (r_dst == D_PREP) begin
            r_rem <= w_hi;
            r_big <= (w_hi >= {1'b0, i_dmag});
            r_sh  <= {r_num[SPLIT-1:0], {FRAC_SHIFT{1'b0}}};
            r_q   <= '0;
        end else if (r_dst == D_RUN) begin
            r_rem <= w_fit ? w_diff[RW-1:0] : w_trial;
            r_q   <= {r_q[QW-2:0], w_fit};
            r_sh  <= {r_sh[QW-2:0], 1'b0};
        end
    end

    always_comb begin
        if (!r_qneg) begin
            o_quot = (r_big || (r_q > Q_MAX)) ? Q_MAX : r_q;
        end else begin
            o_quot = (r_big || (r_q > Q_MIN)) ? Q_MIN : QW'(-r_q);
        end
    end

    assign o_done = (r_dst == D_DONE);

endmodule

// ===== design/m4i_merge.sv =====
// Merge stage: sums lane partial determinants, takes magnitude and sign, flags zero.
module m4i_merge (
    input  logic                   i_clk,
    input  logic [1:0]             i_op,
    input  m4i_pkg::t_acc          i_acc0,
    input  m4i_pkg::t_acc          i_acc1,
    input  m4i_pkg::t_acc          i_acc2,
    output logic [m4i_pkg::AW-1:0] o_dmag,
    output logic                   o_dneg,
    output logic                   o_dzero
);
    import m4i_pkg::*;

    t_acc r_det;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            MG_SUM01: r_det <= i_acc0 + i_acc1;
            MG_ADD2:  r_det <= r_det + i_acc2;
            MG_ABS: begin
                o_dmag  <= r_det[AW-1] ? AW'(-r_det) : AW'(r_det);
                o_dneg  <= r_det[AW-1];
                o_dzero <= (r_det == '0);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/matrix4x4_inverse_unit.sv =====
// Top level of the 4x4 matrix inverse unit: row store, sequencer, four lanes, merge, output register.
// A matrix enters as four row transactions of Q8.8 elements, one per cycle while o_in_ready is
// high; the fourth row starts the computation and the inverse leaves as four Q16.16 row
// transactions (or one singular transaction). After the fourth row the unit forms the 2x2 minors,
// then the determinant, then the zero test, and then each inverse row in turn, using the 32-step
// restoring divider that each of the four lanes runs once per row. The last result may wait in
// the output register while the next matrix is being loaded.
module matrix4x4_inverse_unit #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  m4i_pkg::t_in_item  i_in_data,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output m4i_pkg::t_out_item o_out_data,
    input  logic               i_out_ready
);
    import m4i_pkg::*;

    localparam int EFF = (ELEMENT_BITS < EW) ? ELEMENT_BITS : EW;
    localparam int PAD = EW - EFF;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_MINOR = 3'd1;
    localparam logic [2:0] S_DET   = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SING  = 3'd4;
    localparam logic [2:0] S_COF   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;

    function automatic logic signed [EW-1:0] f_ext(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] v;
        v = x <<< PAD;
        return v >>> PAD;
    endfunction

    logic [2:0]           r_state;
    logic [2:0]           r_step;
    logic [1:0]           r_rows;
    logic [1:0]           r_row;
    logic signed [EW-1:0] r_mat [4][4];
    t_opnd                r_smin [6];
    t_opnd                r_cmin [6];
    logic                 r_out_valid;
    t_out_item            r_out_data;

    t_opnd      w_a [4];
    t_opnd      w_b [4];
    t_mac_ctl   w_ctl [4];
    t_acc       w_acc [4];
    logic [QW-1:0] w_quot [4];
    logic [3:0] w_done;
    logic [1:0] w_mg_op;
    logic       w_div_start;
    logic [AW-1:0] w_dmag;
    logic       w_dneg, w_dzero;
    logic       w_in_acc, w_out_free, w_all_done;
    logic       w_out_load;
    logic [2:0] w_cap;

    assign o_in_ready  = (r_state == S_LOAD);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_all_done  = &w_done;
    assign w_out_load  = w_out_free &&
                         ((r_state == S_SING) || ((r_state == S_DIV) && w_all_done));
    assign w_div_start = (r_state == S_COF) && (r_step == 3'd4);
    assign w_cap       = 3'(r_step[2:1] - 2'd1);

    // lane operand selection
    always_comb begin
        logic [1:0] kb, ra, rb, pi, pj, col, erow, tt;
        logic [2:0] m, q, mi;
        for (int k = 0; k < 4; k++) begin
            kb = 2'(k);
            w_a[k]   = '0;
            w_b[k]   = '0;
            w_ctl[k] = '0;
            unique case (r_state)
                S_MINOR: begin
                    if (r_step < 3'd6) begin
                        m  = 3'({1'b0, r_step[2:1]} + (kb[0] ? 3'd3 : 3'd0));
                        ra = kb[1] ? 2'd2 : 2'd0;
                        rb = 2'(ra + 2'd1);
                        pi = f_pair_i(m);
                        pj = f_pair_j(m);
                        // term 0 adds a[ra][i]*a[rb][j], term 1 subtracts a[rb][i]*a[ra][j]
                        if (!r_step[0]) begin
                            w_a[k] = f_sx(r_mat[ra][pi]);
                            w_b[k] = f_sx(r_mat[rb][pj]);
                        end else begin
                            w_a[k] = f_sx(r_mat[rb][pi]);
                            w_b[k] = f_sx(r_mat[ra][pj]);
                        end
                        w_ctl[k].en  = 1'b1;
                        w_ctl[k].clr = !r_step[0];
                        w_ctl[k].neg = r_step[0];
                    end
                end
                S_DET: begin
                    if (k < 3 && r_step < 3'd2) begin
                        q  = 3'({kb, 1'b0} + {2'b00, r_step[0]});
                        w_a[k] = r_smin[q];
                        w_b[k] = r_cmin[3'(3'd5 - q)];
                        w_ctl[k].en  = 1'b1;
                        w_ctl[k].clr = !r_step[0];
                        w_ctl[k].neg = (q == 3'd1) || (q == 3'd4);
                    end
                end
                S_COF: begin
                    if (r_step < 3'd3) begin
                        tt   = r_step[1:0];
                        col  = f_cof_col(r_row, tt);
                        mi   = f_cof_minor(r_row, tt);
                        // lanes 0..3 expand against rows 1, 0, 3, 2
                        erow = {kb[1], ~kb[0]};
                        w_a[k] = f_sx(r_mat[erow][col]);
                        w_b[k] = kb[1] ? r_smin[mi] : r_cmin[mi];
                        w_ctl[k].en  = 1'b1;
                        w_ctl[k].clr = (tt == 2'd0);
                        w_ctl[k].neg = r_row[0] ^ tt[0] ^ kb[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_mg_op = MG_HOLD;
        if (r_state == S_DET) begin
            unique case (r_step)
                3'd3:    w_mg_op = MG_SUM01;
                3'd4:    w_mg_op = MG_ADD2;
                3'd5:    w_mg_op = MG_ABS;
                default: w_mg_op = MG_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        m4i_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[g]),
            .i_op_a      (w_a[g]),
            .i_op_b      (w_b[g]),
            .i_div_start (w_div_start),
            .i_dmag      (w_dmag),
            .i_dneg      (w_dneg),
            .o_acc       (w_acc[g]),
            .o_quot      (w_quot[g]),
            .o_done      (w_done[g])
        );
    end

    m4i_merge u_merge (
        .i_clk   (i_clk),
        .i_op    (w_mg_op),
        .i_acc0  (w_acc[0]),
        .i_acc1  (w_acc[1]),
        .i_acc2  (w_acc[2]),
        .o_dmag  (w_dmag),
        .o_dneg  (w_dneg),
        .o_dzero (w_dzero)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_step      <= '0;
            r_rows      <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        r_rows <= 2'(r_rows + 2'd1);
                        if (r_rows == 2'd3) begin
                            r_state <= S_MINOR;
                            r_step  <= '0;
                        end
                    end
                end
                S_MINOR: begin
                    if (r_step == 3'd7) begin
                        r_state <= S_DET;
                        r_step  <= '0;
                    end else begin
                        r_step <= 3'(r_step + 3'd1);
                    end
                end
                S_DET: begin
                    r_step <= 3'(r_step + 3'd1);
                    if (r_step == 3'd5) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_step <= '0;
                    r_row  <= '0;
                    r_state <= w_dzero ? S_SING : S_COF;
                end
                S_SING: begin
                    if (w_out_free) begin
                        r_state <= S_LOAD;
                    end
                end
                S_COF: begin
                    r_step <= 3'(r_step + 3'd1);
                    if (r_step == 3'd4) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_all_done && w_out_free) begin
                        r_step      <= '0;
                        r_row       <= 2'(r_row + 2'd1);
                        r_state     <= (r_row == 2'd3) ? S_LOAD : S_COF;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mat[r_rows][0] <= f_ext(i_in_data.elem0);
            r_mat[r_rows][1] <= f_ext(i_in_data.elem1);
            r_mat[r_rows][2] <= f_ext(i_in_data.elem2);
            r_mat[r_rows][3] <= f_ext(i_in_data.elem3);
        end
        // a minor is final once its second term has passed the product and accumulate registers
        if (r_state == S_MINOR && r_step[0] && r_step != 3'd1) begin
            r_smin[w_cap]              <= w_acc[0][MW-1:0];
            r_smin[3'(w_cap + 3'd3)]   <= w_acc[1][MW-1:0];
            r_cmin[w_cap]              <= w_acc[2][MW-1:0];
            r_cmin[3'(w_cap + 3'd3)]   <= w_acc[3][MW-1:0];
        end
        if (r_state == S_SING && w_out_free) begin
            r_out_data <= '{out0: '0, out1: '0, out2: '0, out3: '0,
                            row_number: 2'd0, singular: 1'b1, last: 1'b1};
        end else if (r_state == S_DIV && w_all_done && w_out_free) begin
            r_out_data <= '{out0: w_quot[0], out1: w_quot[1], out2: w_quot[2],
                            out3: w_quot[3], row_number: r_row, singular: 1'b0,
                            last: (r_row == 2'd3)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_done) == 0) || ($countones(w_done) == 4))
        else $error("lane dividers out of step");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.singular |->
            (r_out_data.out0 == '0) && (r_out_data.out1 == '0) &&
            (r_out_data.out2 == '0) && (r_out_data.out3 == '0) &&
            r_out_data.last && (r_out_data.row_number == 2'd0))
        else $error("singular transaction carries data");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.last |->
            (r_out_data.row_number == 2'd3) || r_out_data.singular)
        else $error("last flag on wrong row");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the 4x4 matrix inverse unit.
`timescale 1ns / 100ps

module tb_top;
    import m4i_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_data;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_ready;

    matrix4x4_inverse_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [15:0] mat_rows [16];
    int unsigned        row_cnt;
    t_out_item          inverse_rows [$];
    bit                 any_fail;
    bit                 quiet_tail;
    bit                 hold_off;

    function automatic longint minor3(input int sr, input int sc);
        longint a [3][3];
        int     ri [3];
        int     ci [3];
        int     n;
        int     m;
        n = 0;
        m = 0;
        for (int k = 0; k < 4; k++) begin
            if (k != sr) begin
                ri[n] = k;
                n++;
            end
            if (k != sc) begin
                ci[m] = k;
                m++;
            end
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                a[i][j] = longint'(mat_rows[ri[i] * 4 + ci[j]]);
        return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
             - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
             + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    endfunction

    // cofactor * 2^24 / det, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] q16_quot(input longint cof, input logic signed [95:0] det);
        logic signed [95:0] num;
        logic signed [95:0] q;
        num = 96'(cof) <<< 24;
        q = num / det;
        if (q > 96'sd2147483647) return 32'h7FFF_FFFF;
        if (q < -96'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    task automatic predict_row(input t_in_item it);
        logic signed [95:0] det;
        logic signed [95:0] t;
        t_out_item          r;
        logic [31:0]        v [4];
        mat_rows[row_cnt * 4 + 0] = it.elem0;
        mat_rows[row_cnt * 4 + 1] = it.elem1;
        mat_rows[row_cnt * 4 + 2] = it.elem2;
        mat_rows[row_cnt * 4 + 3] = it.elem3;
        if (row_cnt != 3) begin
            row_cnt++;
            return;
        end
        row_cnt = 0;
        det = '0;
        for (int j = 0; j < 4; j++) begin
            t = 96'(longint'(mat_rows[j])) * 96'(minor3(0, j));
            det = (j & 1) ? det - t : det + t;
        end
        if (det == 0) begin
            r = '0;
            r.singular = 1'b1;
            r.last = 1'b1;
            inverse_rows.push_back(r);
            return;
        end
        for (int rr = 0; rr < 4; rr++) begin
            for (int c = 0; c < 4; c++)
                v[c] = q16_quot(((rr + c) & 1) ? -minor3(c, rr) : minor3(c, rr), det);
            r.out0 = v[0];
            r.out1 = v[1];
            r.out2 = v[2];
            r.out3 = v[3];
            r.row_number = 2'(rr);
            r.singular = 1'b0;
            r.last = (rr == 3);
            inverse_rows.push_back(r);
        end
    endtask

    // valid stays high after acceptance unless a gap follows; drop it once the stream ends
    task automatic send_row(input t_in_item it);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_row(it);
    endtask

    function automatic t_in_item mk(input logic [15:0] a, input logic [15:0] b,
                                    input logic [15:0] c, input logic [15:0] d);
        t_in_item it;
        it.elem0 = a;
        it.elem1 = b;
        it.elem2 = c;
        it.elem3 = d;
        return it;
    endfunction

    function automatic logic [15:0] rnd_elem(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    // receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (inverse_rows.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    any_fail = 1'b1;
                end else begin
                    if (o_out_data !== inverse_rows[0]) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, inverse_rows[0], o_out_data);
                        any_fail = 1'b1;
                    end
                    void'(inverse_rows.pop_front());
                end
            end
            i_out_ready <= hold_off ? 1'b0 :
                           (quiet_tail ? 1'b1 : ($urandom_range(0, 3) != 0));
        end
    end

    // long receiver hold-off, timed in cycles, while the sender keeps offering rows
    initial begin
        hold_off = 1'b0;
        wait (i_rst_n === 1'b1);
        repeat (4000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // stimulus rows: directed table first; identity is typed in for a glance check
    t_in_item dir_rows [24];

    initial begin
        t_out_item ident;
        int        mode;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        any_fail    = 1'b0;
        quiet_tail  = 1'b0;
        row_cnt     = 0;
        // identity
        dir_rows[0]  = mk(16'h0100, 0, 0, 0);
        dir_rows[1]  = mk(0, 16'h0100, 0, 0);
        dir_rows[2]  = mk(0, 0, 16'h0100, 0);
        dir_rows[3]  = mk(0, 0, 0, 16'h0100);
        // all zero: singular
        dir_rows[4]  = mk(0, 0, 0, 0);
        dir_rows[5]  = mk(0, 0, 0, 0);
        dir_rows[6]  = mk(0, 0, 0, 0);
        dir_rows[7]  = mk(0, 0, 0, 0);
        // tiny diagonal: large positive and negative results, still in range
        dir_rows[8]  = mk(16'h0001, 0, 0, 0);
        dir_rows[9]  = mk(0, 16'hFFFF, 0, 0);
        dir_rows[10] = mk(0, 0, 16'h0001, 0);
        dir_rows[11] = mk(0, 0, 0, 16'h0001);
        // extremes on the diagonal, min/max elsewhere
        dir_rows[12] = mk(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        dir_rows[13] = mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        dir_rows[14] = mk(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        dir_rows[15] = mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        // repeated row: singular with nonzero data
        dir_rows[16] = mk(16'h1234, 16'hFEDC, 16'h0042, 16'h8001);
        dir_rows[17] = mk(16'h1234, 16'hFEDC, 16'h0042, 16'h8001);
        dir_rows[18] = mk(16'h0003, 16'h0100, 16'hFFFF, 16'h7000);
        dir_rows[19] = mk(16'h0F00, 16'h0010, 16'h0200, 16'h0001);
        // full swing diagonal
        dir_rows[20] = mk(16'h8000, 0, 0, 0);
        dir_rows[21] = mk(0, 16'h7FFF, 0, 0);
        dir_rows[22] = mk(0, 0, 16'hFFFF, 0);
        dir_rows[23] = mk(0, 0, 0, 16'h8000);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++) begin
            send_row(dir_rows[i]);
            if (i == 3) begin
                // identity in Q16.16: a glance check on the first matrix
                ident = inverse_rows[0];
                if (ident.out0 !== 32'h0001_0000 || ident.out1 !== 0 || ident.last !== 1'b0) begin
                    $display("%0t: mismatch expected identity row actual %h", $time, ident);
                    any_fail = 1'b1;
                end
            end
        end

        // random matrices
        for (int m = 0; m < 102; m++) begin
            if (m == 85) quiet_tail = 1'b1;
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) begin
                // broken rank: two equal rows
                dir_rows[0] = mk(rnd_elem(mode), rnd_elem(mode), rnd_elem(mode), rnd_elem(mode));
                dir_rows[1] = mk(rnd_elem(mode), rnd_elem(mode), rnd_elem(mode), rnd_elem(mode));
                dir_rows[2] = dir_rows[$urandom_range(0, 1)];
                dir_rows[3] = mk(rnd_elem(mode), rnd_elem(mode), rnd_elem(mode), rnd_elem(mode));
            end else begin
                for (int r = 0; r < 4; r++)
                    dir_rows[r] = mk(rnd_elem(mode), rnd_elem(mode),
                                     rnd_elem(mode), rnd_elem(mode));
            end
            for (int r = 0; r < 4; r++)
                send_row(dir_rows[r]);
        end
        i_in_valid <= 1'b0;

        while (inverse_rows.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!any_fail)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/m4i_pkg.sv
design/m4i_lane.sv
design/m4i_merge.sv
design/matrix4x4_inverse_unit.sv
verif/tb_top.sv
